@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared implication forms used by the scheduler checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MRR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MRR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

@@ sv/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg
// constants, widths and codes of the multicore round-robin scheduler
// ----------------------------------------------------------------------------
package mrr_pkg;

    localparam int MAX_CORES   = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int CORE_W   = $clog2(MAX_CORES);
    localparam int NCORE_W  = $clog2(MAX_CORES + 1);
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_D  = MAX_CORES * QUEUE_DEPTH;
    localparam int ADDR_W   = $clog2(STORE_D);

    localparam int ACTIVE_W = 4;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 8;
    localparam int COREID_W = 4;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 2 * ID_W + SLOT_W;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_CORE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd3;

endpackage

@@ sv/mrr_ram.sv @@
// ----------------------------------------------------------------------------
// mrr_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module mrr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/multicore_round_robin_scheduler.sv @@
// ----------------------------------------------------------------------------
// multicore_round_robin_scheduler
// per-core thread fifos in one ram; adds go to the shortest active queue,
// a tick runs the head thread of every non-empty active core once
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         start, busy          req_type, req_process, req_thread, slots
// config    in         cfg_valid, cfg_ready cfg_data (active core count)
// result    out        done (one cycle)     kind, core_id, status, run_process,
//                                           run_thread, slots_left, last
//
// an add answers in the cycle after start and busy stays low, so the next
// request is taken in that same cycle
// a tick holds busy while it scans the cores up to the last non-empty one
// and reads the head entry of each non-empty core; when nothing is queued
// it scans all active cores and emits no result
// reset clears queue pointers, counts and the active core count; results cannot stall
// ----------------------------------------------------------------------------
module multicore_round_robin_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [mrr_pkg::ID_W-1:0]      req_process,
    input  logic [mrr_pkg::ID_W-1:0]      req_thread,
    input  logic [mrr_pkg::SLOT_W-1:0]    slots,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mrr_pkg::ACTIVE_W-1:0]  cfg_data,
    output logic                          done,
    output logic                          kind,
    output logic [mrr_pkg::COREID_W-1:0]  core_id,
    output logic [mrr_pkg::STATUS_W-1:0]  status,
    output logic [mrr_pkg::ID_W-1:0]      run_process,
    output logic [mrr_pkg::ID_W-1:0]      run_thread,
    output logic [mrr_pkg::SLOT_W-1:0]    slots_left,
    output logic                          last
);

    import mrr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    state_t               state_reg, state_next;
    logic [ACTIVE_W-1:0]  active_reg, active_next;
    logic [NCORE_W-1:0]   scan_reg, scan_next;
    logic [PTR_W-1:0]     head_reg [MAX_CORES];
    logic [PTR_W-1:0]     head_next [MAX_CORES];
    logic [PTR_W-1:0]     tail_reg [MAX_CORES];
    logic [PTR_W-1:0]     tail_next [MAX_CORES];
    logic [CNT_W-1:0]     cnt_reg [MAX_CORES];
    logic [CNT_W-1:0]     cnt_next [MAX_CORES];

    logic                 done_reg, done_next;
    logic                 kind_reg, kind_next;
    logic [COREID_W-1:0]  core_reg, core_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    logic [ID_W-1:0]      tid_reg, tid_next;
    logic [SLOT_W-1:0]    left_reg, left_next;
    logic                 last_reg, last_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [NCORE_W-1:0]   n_used;
    logic [CORE_W-1:0]    best_idx;
    logic [CNT_W-1:0]     best_cnt;
    logic                 later_busy;
    logic [CORE_W-1:0]    scan_core;
    logic [SLOT_W-1:0]    run_left;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [CORE_W-1:0] c,
                                                     input logic [PTR_W-1:0]  p);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
        return a;
    endfunction

    mrr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_D)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign done        = done_reg;
    assign kind        = kind_reg;
    assign core_id     = core_reg;
    assign status      = status_reg;
    assign run_process = pid_reg;
    assign run_thread  = tid_reg;
    assign slots_left  = left_reg;
    assign last        = last_reg;

    // active count above the core total acts as the total
    assign n_used = (active_reg > ACTIVE_W'(MAX_CORES)) ? NCORE_W'(MAX_CORES)
                                                          : NCORE_W'(active_reg);

    assign scan_core = scan_reg[CORE_W-1:0];
    assign ram_raddr = store_addr(scan_core, head_reg[scan_core]);
    assign run_left  = ram_rdata[SLOT_W-1:0] - SLOT_W'(1);

    // shortest queue, ties to the lowest core
    always_comb
    begin
        best_idx = '0;
        best_cnt = cnt_reg[0];
        for (int c = 1; c < MAX_CORES; c++)
        begin
            if (NCORE_W'(c) < n_used && cnt_reg[c] < best_cnt)
            begin
                best_idx = CORE_W'(c);
                best_cnt = cnt_reg[c];
            end
        end
    end

    // any later active core still holding a thread
    always_comb
    begin
        later_busy = 1'b0;
        for (int c = 0; c < MAX_CORES; c++)
        begin
            if (NCORE_W'(c) > scan_reg && NCORE_W'(c) < n_used && cnt_reg[c] != '0)
            begin
                later_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        scan_next   = scan_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        kind_next   = kind_reg;
        core_next   = core_reg;
        status_next = status_reg;
        pid_next    = pid_reg;
        tid_next    = tid_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = store_addr(best_idx, tail_reg[best_idx]);
        ram_wdata   = {req_process, req_thread, slots};

        if (cfg_valid && cfg_ready)
        begin
            active_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ADD)
                    begin
                        done_next   = 1'b1;
                        kind_next   = KIND_ADD;
                        last_next   = 1'b1;
                        pid_next    = req_process;
                        tid_next    = req_thread;
                        left_next   = slots;
                        core_next   = '0;
                        if (n_used == '0)
                        begin
                            status_next = STATUS_NO_CORE;
                        end
                        else if (slots == '0)
                        begin
                            status_next = STATUS_ZERO;
                        end
                        else if (best_cnt >= CNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            status_next         = STATUS_OK;
                            core_next           = COREID_W'(best_idx) + COREID_W'(1);
                            ram_we              = 1'b1;
                            tail_next[best_idx] = wrap_next(tail_reg[best_idx]);
                            cnt_next[best_idx]  = cnt_reg[best_idx] + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_reg >= n_used)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_reg[scan_core] == '0)
                begin
                    scan_next = scan_reg + NCORE_W'(1);
                end
                else
                begin
                    // head entry read is issued this cycle
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                head_next[scan_core] = wrap_next(head_reg[scan_core]);
                if (run_left != '0)
                begin
                    // requeue at the tail; a full queue overwrites the slot just read
                    ram_we                = 1'b1;
                    ram_waddr             = store_addr(scan_core, tail_reg[scan_core]);
                    ram_wdata             = {ram_rdata[ENTRY_W-1:SLOT_W], run_left};
                    tail_next[scan_core]  = wrap_next(tail_reg[scan_core]);
                end
                else
                begin
                    cnt_next[scan_core] = cnt_reg[scan_core] - CNT_W'(1);
                end
                done_next   = 1'b1;
                kind_next   = KIND_RUN;
                core_next   = COREID_W'(scan_reg) + COREID_W'(1);
                status_next = STATUS_OK;
                pid_next    = ram_rdata[ENTRY_W-1:ENTRY_W-ID_W];
                tid_next    = ram_rdata[SLOT_W+ID_W-1:SLOT_W];
                left_next   = run_left;
                last_next   = !later_busy;
                scan_next   = scan_reg + NCORE_W'(1);
                state_next  = later_busy ? ST_SCAN : ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            scan_reg   <= '0;
            done_reg   <= 1'b0;
            kind_reg   <= 1'b0;
            core_reg   <= '0;
            status_reg <= '0;
            pid_reg    <= '0;
            tid_reg    <= '0;
            left_reg   <= '0;
            last_reg   <= 1'b0;
            for (int c = 0; c < MAX_CORES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            scan_reg   <= scan_next;
            done_reg   <= done_next;
            kind_reg   <= kind_next;
            core_reg   <= core_next;
            status_reg <= status_next;
            pid_reg    <= pid_next;
            tid_reg    <= tid_next;
            left_reg   <= left_next;
            last_reg   <= last_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/mrr_checker.sv @@
// ----------------------------------------------------------------------------
// mrr_checker
// port-level checks of the scheduler result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          req_type,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          done,
    input  logic                          kind,
    input  logic [mrr_pkg::COREID_W-1:0]  core_id,
    input  logic [mrr_pkg::STATUS_W-1:0]  status,
    input  logic                          last
);

    import mrr_pkg::*;

    // an add answers with exactly one result in the next cycle
    `MRR_ASSERT_NXT(a_add_result, clk, rst_n, start && !busy && req_type == REQ_ADD, done && kind == KIND_ADD && last)

    // a failed add names no core
    `MRR_ASSERT_IMP(a_fail_no_core, clk, rst_n, done && status != STATUS_OK, core_id == '0)

    // a run result is always ok and names a real core
    `MRR_ASSERT_IMP(a_run_core, clk, rst_n, done && kind == KIND_RUN, status == STATUS_OK && core_id != '0)

    // a tick transaction that is not finished keeps the block busy
    `MRR_ASSERT_IMP(a_run_busy, clk, rst_n, done && kind == KIND_RUN && !last, busy)

    // configuration is only taken while idle
    `MRR_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, !busy)

endmodule

bind multicore_round_robin_scheduler mrr_checker u_mrr_checker (.*);

@@ tb/multicore_round_robin_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multicore_round_robin_scheduler_tb
// drives add and tick requests through the start/busy port and checks every
// done strobe against a cycle-free scheduler predictor kept in the bench;
// a directed table covers error codes and extremes, then random traffic
// runs under several active-core settings and sender idling patterns
// ----------------------------------------------------------------------------
module multicore_round_robin_scheduler_tb;

    import mrr_pkg::*;

    // a tick scans the cores up to the last busy one and also reads the head of each busy one
    localparam int SETTLE_CYCLES = 2 * MAX_CORES + 8;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic                kind;
        logic [COREID_W-1:0] core;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     pid;
        logic [ID_W-1:0]     tid;
        logic [SLOT_W-1:0]   left;
        logic                last;
    } sched_result_t;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [SLOT_W-1:0] slots;
    } thread_t;

    typedef struct packed {
        logic                is_cfg;
        logic [ACTIVE_W-1:0] cfg_val;
        logic [7:0]          count;
        logic                rt;
        logic [ID_W-1:0]     pid;
        logic [ID_W-1:0]     tid;
        logic [SLOT_W-1:0]   sl;
        logic                pinned;
        sched_result_t       res;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [11] = '{
        // no active core after reset
        '{1'b0, 4'd0, 8'd1, REQ_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{KIND_ADD, 4'd0, STATUS_NO_CORE, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        // above the core count, acts as all cores
        '{1'b1, 4'd15, 8'd0, REQ_ADD, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{1'b0, 4'd0, 8'd1, REQ_ADD, 8'h00, 8'h00, 8'h00, 1'b1,
          '{KIND_ADD, 4'd0, STATUS_ZERO, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_ADD, 8'h00, 8'h00, 8'h01, 1'b1,
          '{KIND_ADD, 4'd1, STATUS_OK, 8'h00, 8'h00, 8'h01, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{KIND_ADD, 4'd2, STATUS_OK, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        // core 2 keeps its thread while inactive
        '{1'b1, 4'd1, 8'd0, REQ_ADD, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{1'b0, 4'd0, 8'd16, REQ_ADD, 8'hA5, 8'h5A, 8'h02, 1'b1,
          '{KIND_ADD, 4'd1, STATUS_OK, 8'hA5, 8'h5A, 8'h02, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_ADD, 8'h5A, 8'hA5, 8'h03, 1'b1,
          '{KIND_ADD, 4'd0, STATUS_FULL, 8'h5A, 8'hA5, 8'h03, 1'b1}},
        '{1'b0, 4'd0, 8'd1, REQ_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [ID_W-1:0]     req_process;
    logic [ID_W-1:0]     req_thread;
    logic [SLOT_W-1:0]   slots;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data;
    logic                done;
    logic                kind;
    logic [COREID_W-1:0] core_id;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     run_process;
    logic [ID_W-1:0]     run_thread;
    logic [SLOT_W-1:0]   slots_left;
    logic                last;

    // predictor state
    thread_t             core_fifo [MAX_CORES][QUEUE_DEPTH];
    int unsigned         fifo_head [MAX_CORES];
    int unsigned         fifo_tail [MAX_CORES];
    int unsigned         fifo_fill [MAX_CORES];
    logic [ACTIVE_W-1:0] active_setting;

    sched_result_t       awaited_results [$];
    logic                pin_valid;
    sched_result_t       pin_result;
    int                  mismatch_count;
    int                  stall_cycles;

    always #5 clk = ~clk;

    multicore_round_robin_scheduler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .req_process (req_process),
        .req_thread  (req_thread),
        .slots       (slots),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .kind        (kind),
        .core_id     (core_id),
        .status      (status),
        .run_process (run_process),
        .run_thread  (run_thread),
        .slots_left  (slots_left),
        .last        (last)
    );

    // appends one result to the awaited list
    function automatic void await_result(input sched_result_t r);
        awaited_results = {awaited_results, r};
    endfunction

    // works out the results of one request and queues them as awaited
    task automatic schedule_request(input logic rt, input logic [ID_W-1:0] pid,
                                    input logic [ID_W-1:0] tid,
                                    input logic [SLOT_W-1:0] sl);
        int unsigned       n;
        int unsigned       best;
        sched_result_t     r;
        sched_result_t     held;
        bit                have_held;
        thread_t           t;
        logic [SLOT_W-1:0] left;
        n = (active_setting > MAX_CORES) ? MAX_CORES : active_setting;
        have_held = 1'b0;
        if (rt == REQ_ADD)
        begin
            r = '{KIND_ADD, '0, STATUS_OK, pid, tid, sl, 1'b1};
            if (n == 0)
            begin
                r.status = STATUS_NO_CORE;
            end
            else if (sl == 0)
            begin
                r.status = STATUS_ZERO;
            end
            else
            begin
                best = 0;
                for (int c = 1; c < n; c++)
                begin
                    if (fifo_fill[c] < fifo_fill[best])
                        best = c;
                end
                if (fifo_fill[best] >= QUEUE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    core_fifo[best][fifo_tail[best]] = '{pid, tid, sl};
                    fifo_tail[best] = (fifo_tail[best] + 1) % QUEUE_DEPTH;
                    fifo_fill[best]++;
                    r.core = COREID_W'(best + 1);
                end
            end
            await_result(r);
        end
        else
        begin
            for (int c = 0; c < n; c++)
            begin
                if (fifo_fill[c] != 0)
                begin
                    t = core_fifo[c][fifo_head[c]];
                    fifo_head[c] = (fifo_head[c] + 1) % QUEUE_DEPTH;
                    fifo_fill[c]--;
                    left = t.slots - 1'b1;
                    if (left != 0)
                    begin
                        core_fifo[c][fifo_tail[c]] = '{t.pid, t.tid, left};
                        fifo_tail[c] = (fifo_tail[c] + 1) % QUEUE_DEPTH;
                        fifo_fill[c]++;
                    end
                    if (have_held)
                        await_result(held);
                    held = '{KIND_RUN, COREID_W'(c + 1), STATUS_OK, t.pid, t.tid, left, 1'b0};
                    have_held = 1'b1;
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                await_result(held);
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no transaction awaiting it");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("core_id", want.core, core_id);
                    check_field("status", want.status, status);
                    check_field("run_process", want.pid, run_process);
                    check_field("run_thread", want.tid, run_thread);
                    check_field("slots_left", want.left, slots_left);
                    check_field("last", want.last, last);
                end
            end
            if (start && !busy)
            begin
                schedule_request(req_type, req_process, req_thread, slots);
                if (pin_valid)
                begin
                    void'(awaited_results.pop_back());
                    await_result(pin_result);
                end
            end
            if (cfg_valid && cfg_ready)
                active_setting = cfg_data;
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input logic rt, input logic [ID_W-1:0] pid,
                                input logic [ID_W-1:0] tid,
                                input logic [SLOT_W-1:0] sl, input logic pin,
                                input sched_result_t pres);
        @(negedge clk);
        pin_valid   = pin;
        pin_result  = pres;
        start       <= 1'b1;
        req_type    <= rt;
        req_process <= pid;
        req_thread  <= tid;
        slots       <= sl;
        do @(posedge clk); while (busy);
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // hold requests until every awaited result is in and the block settles
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                  n_items;
        int                  add_pct;
        int                  idle_pct;
        int                  roll;
        logic                rt;
        logic [SLOT_W-1:0]   sl;
        logic [ACTIVE_W-1:0] seg_cfg;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_ADD;
        req_process    = '0;
        req_thread     = '0;
        slots          = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        pin_valid      = 1'b0;
        pin_result     = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        active_setting = '0;
        for (int c = 0; c < MAX_CORES; c++)
        begin
            fifo_head[c] = 0;
            fifo_tail[c] = 0;
            fifo_fill[c] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].is_cfg)
            begin
                drain_results();
                write_active(DIRECTED_ROWS[i].cfg_val);
            end
            else
            begin
                repeat (DIRECTED_ROWS[i].count)
                    send_request(DIRECTED_ROWS[i].rt, DIRECTED_ROWS[i].pid,
                                 DIRECTED_ROWS[i].tid, DIRECTED_ROWS[i].sl,
                                 DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res);
            end
        end

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0: seg_cfg = 4'd8;
                1: seg_cfg = 4'd1;
                2: seg_cfg = 4'd15;
                3: seg_cfg = 4'd0;
                4: seg_cfg = 4'd5;
                default: seg_cfg = ACTIVE_W'($urandom_range(2, 7));
            endcase
            idle_pct = (seg < 2) ? 9 : (seg < 4) ? 72 : 0;
            n_items  = (seg_cfg == 0) ? 20 : 90;
            // a single core fills up only when adds clearly outnumber ticks
            add_pct  = (seg_cfg == 1) ? 80 : 60;
            drain_results();
            write_active(seg_cfg);
            for (int k = 0; k < n_items; k++)
            begin
                sender_gap(idle_pct);
                if ($urandom_range(99) == 0)
                    drain_results();
                rt   = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_TICK;
                roll = $urandom_range(99);
                if (roll < 8)
                    sl = '0;
                else if (roll < 85)
                    sl = SLOT_W'($urandom_range(1, 6));
                else
                    sl = SLOT_W'($urandom_range(255));
                send_request(rt, ID_W'($urandom_range(255)), ID_W'($urandom_range(255)),
                             sl, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
